// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/gtp_pkg.sv -----
// Types, constants, hex decoding and layout templates for the GUID text parser.
package gtp_pkg;

    localparam int LAY_N     = 0;
    localparam int LAY_D     = 1;
    localparam int LAY_B     = 2;
    localparam int LAY_P     = 3;
    localparam int LAY_X     = 4;
    localparam int LAY_COUNT = 5;

    localparam logic [6:0] POS_MAX = 7'd127;
    localparam logic [6:0] LEN_N   = 7'd32;
    localparam logic [6:0] LEN_D   = 7'd36;
    localparam logic [6:0] LEN_B   = 7'd38;
    localparam logic [6:0] LEN_P   = 7'd38;
    localparam logic [6:0] LEN_X   = 7'd68;

    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FMT_N = 3'd0,
        FMT_D = 3'd1,
        FMT_B = 3'd2,
        FMT_P = 3'd3,
        FMT_X = 3'd4
    } t_fmt;

    typedef struct packed {
        logic       is_hex;
        logic [7:0] ch;
    } t_tmpl;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Hyphenated layout, 8-4-4-4-12.
    function automatic t_tmpl tmpl_d(input logic [6:0] p);
        t_tmpl t;
        t.is_hex = 1'b0;
        t.ch     = CH_DASH;
        case (p)
            7'd8, 7'd13, 7'd18, 7'd23: t.is_hex = 1'b0;
            default:                   t.is_hex = 1'b1;
        endcase
        return t;
    endfunction

    // Prefixed layout {0xhhhhhhhh,0xhhhh,0xhhhh,{0xhh,...,0xhh}}
    function automatic t_tmpl tmpl_x(input logic [6:0] p);
        t_tmpl t;
        t.is_hex = 1'b0;
        t.ch     = 8'h00;
        case (p)
            7'd0, 7'd26: t.ch = CH_LBRACE;
            7'd66, 7'd67: t.ch = CH_RBRACE;
            7'd11, 7'd18, 7'd25, 7'd31, 7'd36, 7'd41, 7'd46, 7'd51, 7'd56, 7'd61:
                t.ch = CH_COMMA;
            7'd1, 7'd12, 7'd19, 7'd27, 7'd32, 7'd37, 7'd42, 7'd47, 7'd52, 7'd57, 7'd62:
                t.ch = CH_ZERO;
            7'd2, 7'd13, 7'd20, 7'd28, 7'd33, 7'd38, 7'd43, 7'd48, 7'd53, 7'd58, 7'd63:
                t.ch = CH_LOW_X;
            default: t.is_hex = 1'b1;
        endcase
        return t;
    endfunction

    function automatic logic tmpl_match(input t_tmpl t, input logic hv, input logic [7:0] c);
        return t.is_hex ? hv : (t.ch == c);
    endfunction

    // Layouts that accept character c at position p.
    function automatic logic [LAY_COUNT-1:0] fit_mask(input logic [6:0] p, input logic [7:0] c,
                                                      input logic hv);
        logic [LAY_COUNT-1:0] m;
        logic [6:0]           pm1;
        pm1 = p - 7'd1;
        m[LAY_N] = (p < LEN_N) && hv;
        m[LAY_D] = (p < LEN_D) && tmpl_match(tmpl_d(p), hv, c);
        if (p == 7'd0) begin
            m[LAY_B] = (c == CH_LBRACE);
            m[LAY_P] = (c == CH_LPAREN);
        end else if (p == LEN_B - 7'd1) begin
            m[LAY_B] = (c == CH_RBRACE);
            m[LAY_P] = (c == CH_RPAREN);
        end else begin
            m[LAY_B] = (p < LEN_B) && tmpl_match(tmpl_d(pm1), hv, c);
            m[LAY_P] = (p < LEN_P) && tmpl_match(tmpl_d(pm1), hv, c);
        end
        m[LAY_X] = (p < LEN_X) && tmpl_match(tmpl_x(p), hv, c);
        return m;
    endfunction

endpackage

// ----- rtl/guid_text_parser.sv -----
// GUID text parser: per-character layout check, digit capture and result register.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_text_char, i_char_present, i_last_char
//  result   out        o_valid / i_stall    o_status, o_format_found, o_value_high, o_value_low
//
// One character per cycle while o_stall is low; the result appears the cycle after the item
// with the last mark. The rate is set by one position/template compare and a 128-bit nibble
// shift per cycle. Synchronous active-low reset clears the position, digits and result valid
// and sets every layout mask bit. Items without the last mark are taken even while a result
// waits; an item with the last mark stalls only while the held result is itself stalled.
module guid_text_parser
    import gtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_char,
    input  logic        i_char_present,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_format_found,
    output logic [63:0] o_value_high,
    output logic [63:0] o_value_low
);

    logic [6:0]           r_pos,  n_pos;
    logic [LAY_COUNT-1:0] r_poss, n_poss;
    logic [127:0]         r_hex,  n_hex;
    logic [127:0]         r_pfx,  n_pfx;

    logic                 r_ovalid;
    t_status              r_status;
    t_fmt                 r_fmt;
    logic [127:0]         r_value;

    logic                 in_acc;
    logic                 res_load;
    t_hex                 hx;
    t_tmpl                xt;
    logic [6:0]           s_pos;
    logic [LAY_COUNT-1:0] s_poss;
    logic [127:0]         s_hex;
    logic [127:0]         s_pfx;
    t_status              res_status;
    t_fmt                 res_fmt;
    logic [127:0]         res_value;

    assign o_stall  = r_ovalid && i_stall && i_last_char;
    assign in_acc   = i_valid && !o_stall;
    assign res_load = in_acc && i_last_char;

    assign hx = hex_decode(i_text_char);
    assign xt = tmpl_x(r_pos);

    always_comb begin
        s_pos  = r_pos;
        s_poss = r_poss;
        s_hex  = r_hex;
        s_pfx  = r_pfx;
        if (i_char_present) begin
            s_poss = r_poss & fit_mask(r_pos, i_text_char, hx.ok);
            if (hx.ok) begin
                s_hex = {r_hex[123:0], hx.nib};
                if (r_pos < LEN_X && xt.is_hex) begin
                    s_pfx = {r_pfx[123:0], hx.nib};
                end
            end
            if (r_pos != POS_MAX) begin
                s_pos = r_pos + 7'd1;
            end
        end

        res_status = ST_BAD;
        res_fmt    = FMT_N;
        res_value  = '0;
        if (s_pos == 7'd0) begin
            res_status = ST_EMPTY;
        end else if (s_poss[LAY_N] && s_pos == LEN_N) begin
            res_status = ST_OK;
            res_fmt    = FMT_N;
            res_value  = s_hex;
        end else if (s_poss[LAY_D] && s_pos == LEN_D) begin
            res_status = ST_OK;
            res_fmt    = FMT_D;
            res_value  = s_hex;
        end else if (s_poss[LAY_B] && s_pos == LEN_B) begin
            res_status = ST_OK;
            res_fmt    = FMT_B;
            res_value  = s_hex;
        end else if (s_poss[LAY_P] && s_pos == LEN_P) begin
            res_status = ST_OK;
            res_fmt    = FMT_P;
            res_value  = s_hex;
        end else if (s_poss[LAY_X] && s_pos == LEN_X) begin
            res_status = ST_OK;
            res_fmt    = FMT_X;
            res_value  = s_pfx;
        end

        n_pos  = r_pos;
        n_poss = r_poss;
        n_hex  = r_hex;
        n_pfx  = r_pfx;
        if (in_acc) begin
            if (i_last_char) begin
                n_pos  = '0;
                n_poss = '1;
                n_hex  = '0;
                n_pfx  = '0;
            end else begin
                n_pos  = s_pos;
                n_poss = s_poss;
                n_hex  = s_hex;
                n_pfx  = s_pfx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_poss <= '1;
            r_hex  <= '0;
            r_pfx  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_poss <= n_poss;
            r_hex  <= n_hex;
            r_pfx  <= n_pfx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= res_status;
            r_fmt    <= res_fmt;
            r_value  <= res_value;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_format_found = r_fmt;
    assign o_value_high   = r_value[127:64];
    assign o_value_low    = r_value[63:0];

endmodule

// ----- rtl/gtp_checker.sv -----
// Port-level checks for the GUID text parser, bound into guid_text_parser.
`include "assert_macros.svh"

module gtp_checker
    import gtp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_text_char,
    input logic        i_char_present,
    input logic        i_last_char,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [2:0]  o_format_found,
    input logic [63:0] o_value_high,
    input logic [63:0] o_value_low
);

    logic         last_acc;
    logic         not_ok_clean;
    logic [132:0] out_word;

    assign last_acc     = i_valid && !o_stall && i_last_char;
    assign not_ok_clean = (o_format_found == FMT_N) && (o_value_high == 64'd0)
                          && (o_value_low == 64'd0);
    assign out_word     = {o_status, o_format_found, o_value_high, o_value_low};

    `ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_word))
    `ASSERT_NEXT(a_last_gives_result, last_acc, o_valid)
    `ASSERT_NOW(a_result_has_cause, $rose(o_valid), $past(last_acc))
    `ASSERT_NOW(a_not_ok_zeroed, o_valid && o_status != ST_OK, not_ok_clean)
    `ASSERT_NOW(a_status_range, o_valid, o_status != 2'd3 && o_format_found <= FMT_X)

endmodule

bind guid_text_parser gtp_checker u_gtp_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for guid_text_parser: directed and random GUID texts with a scoreboard.
module tb_top
    import gtp_pkg::*;
();

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_CHARS = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [7:0] HEX_SLOT = "h";

    typedef struct packed {
        logic       drain;
        logic [7:0] ch;
        logic       present;
        logic       last;
    } t_text_item;

    typedef struct packed {
        t_status     status;
        t_fmt        fmt;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_guid_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_text_char = 8'h00;
    logic        i_char_present = 1'b0;
    logic        i_last_char = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_format_found;
    logic [63:0] o_value_high;
    logic [63:0] o_value_low;

    t_text_item   text_q[$];
    t_guid_result pending_results[$];
    t_text_item   on_bus;

    // predictor state
    logic [6:0]           char_pos;
    logic [LAY_COUNT-1:0] layouts_alive;
    logic [127:0]         all_digits;
    logic [127:0]         x_digits;

    int  error_count = 0;
    int  char_count = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  next_hold_at = 8;
    wire calm = (cycle_count % 1024) < 200;

    guid_text_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_char    (i_text_char),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_format_found (o_format_found),
        .o_value_high   (o_value_high),
        .o_value_low    (o_value_low)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic string layout_text(int k);
        case (k)
            LAY_N: return "hhhhhhhhhhhhhhhhhhhhhhhhhhhhhhhh";
            LAY_D: return "hhhhhhhh-hhhh-hhhh-hhhh-hhhhhhhhhhhh";
            LAY_B: return "{hhhhhhhh-hhhh-hhhh-hhhh-hhhhhhhhhhhh}";
            LAY_P: return "(hhhhhhhh-hhhh-hhhh-hhhh-hhhhhhhhhhhh)";
            default: return "{0xhhhhhhhh,0xhhhh,0xhhhh,{0xhh,0xhh,0xhh,0xhh,0xhh,0xhh,0xhh,0xhh}}";
        endcase
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // digit_mode < 0: random digits; case_mode 0 lower, 1 upper, 2 mixed
    function automatic string fill_layout(int k, int digit_mode, int case_mode);
        string s;
        logic [3:0] v;
        bit upper;
        s = layout_text(k);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == HEX_SLOT) begin
                v = (digit_mode < 0) ? 4'($urandom_range(0, 15)) : 4'(digit_mode);
                upper = (case_mode == 2) ? bit'($urandom_range(0, 1)) : bit'(case_mode);
                s.putc(i, hex_char(v, upper));
            end
        end
        return s;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic clear_parse_state();
        char_pos      = '0;
        layouts_alive = '1;
        all_digits    = '0;
        x_digits      = '0;
    endtask

    task automatic absorb_item(t_text_item it);
        string s;
        string xs;
        int hv;
        bit fits;
        bit found;
        t_guid_result res;
        xs = layout_text(LAY_X);
        if (it.present) begin
            hv = nibble_of(it.ch);
            for (int k = 0; k < LAY_COUNT; k++) begin
                s = layout_text(k);
                fits = 1'b0;
                if (int'(char_pos) < s.len()) begin
                    if (s[char_pos] == HEX_SLOT) fits = (hv >= 0);
                    else fits = (s[char_pos] == it.ch);
                end
                if (!fits) layouts_alive[k] = 1'b0;
            end
            if (hv >= 0) begin
                all_digits = {all_digits[123:0], 4'(hv)};
                if (int'(char_pos) < xs.len() && xs[char_pos] == HEX_SLOT)
                    x_digits = {x_digits[123:0], 4'(hv)};
            end
            if (char_pos != POS_MAX) char_pos = char_pos + 7'd1;
        end
        if (it.last) begin
            res = '{ST_BAD, FMT_N, 64'd0, 64'd0};
            found = 1'b0;
            if (char_pos == 7'd0) begin
                res.status = ST_EMPTY;
            end else begin
                for (int k = 0; k < LAY_COUNT; k++) begin
                    s = layout_text(k);
                    if (!found && layouts_alive[k] && int'(char_pos) == s.len()) begin
                        found = 1'b1;
                        res.status = ST_OK;
                        res.fmt = t_fmt'(k);
                        {res.hi, res.lo} = (k == LAY_X) ? x_digits : all_digits;
                    end
                end
            end
            pending_results.push_back(res);
            clear_parse_state();
        end
    endtask

    task automatic push_char(logic [7:0] c, bit last);
        text_q.push_back('{1'b0, c, 1'b1, last});
        char_count++;
    endtask

    task automatic push_nop();
        text_q.push_back('{1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0});
    endtask

    task automatic push_end();
        text_q.push_back('{1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b1});
    endtask

    task automatic push_drain();
        text_q.push_back('{1'b1, 8'h00, 1'b0, 1'b0});
    endtask

    // split_end: the text ends with a mark that carries no character
    task automatic push_text(string s, bit split_end);
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(0, 99) < 3) push_nop();
            push_char(s[i], !split_end && i == s.len() - 1);
        end
        if (split_end || s.len() == 0) push_end();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
        error_count++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) absorb_item(on_bus);
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (text_q.size() != 0 && text_q[0].drain) begin
                i_valid <= 1'b0;
                if (pending_results.size() == 0) void'(text_q.pop_front());
            end else if (text_q.size() != 0) begin
                on_bus = text_q.pop_front();
                i_text_char    <= on_bus.ch;
                i_char_present <= on_bus.present;
                i_last_char    <= on_bus.last;
                i_valid        <= 1'b1;
                gap_left <= (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen == next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 30;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_guid_result want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, status", 64'(o_status), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_format_found !== want.fmt)
                        report_mismatch("format", 64'(o_format_found), 64'(want.fmt));
                    if (o_value_high !== want.hi)
                        report_mismatch("value_high", o_value_high, want.hi);
                    if (o_value_low !== want.lo)
                        report_mismatch("value_low", o_value_low, want.lo);
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left <= idle_len() - 1;
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[guid_text_parser] ERROR");
            $finish;
        end
    end

    initial begin
        string s;
        int r;
        int k;
        int n;
        int next_drain;
        clear_parse_state();

        // directed
        push_end();
        push_nop();
        push_text(fill_layout(LAY_N, 0, 0), 1'b0);
        push_text(fill_layout(LAY_N, 15, 1), 1'b0);
        push_text(fill_layout(LAY_N, -1, 2), 1'b0);
        push_text(fill_layout(LAY_D, 15, 0), 1'b0);
        push_text(fill_layout(LAY_D, -1, 2), 1'b1);
        push_text(fill_layout(LAY_B, 0, 0), 1'b0);
        push_text(fill_layout(LAY_P, 15, 1), 1'b0);
        push_text(fill_layout(LAY_X, 15, 2), 1'b0);
        push_text(fill_layout(LAY_X, 0, 0), 1'b1);
        s = fill_layout(LAY_X, -1, 2);
        s.putc(2, "X");
        push_text(s, 1'b0);
        s = fill_layout(LAY_B, -1, 2);
        s.putc(37, ")");
        push_text(s, 1'b0);
        push_text({fill_layout(LAY_X, -1, 2), "0"}, 1'b0);
        push_text({fill_layout(LAY_D, -1, 0), "a"}, 1'b1);
        for (int i = 0; i < 130; i++) push_char(hex_char(4'($urandom_range(0, 15)), 1'b1), i == 129);
        push_text("a", 1'b0);
        push_drain();

        // random
        next_drain = char_count + 500;
        while (char_count < TARGET_CHARS) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, LAY_COUNT - 1);
            if (r < 70) begin
                push_text(fill_layout(k, -1, 2), $urandom_range(0, 99) < 20);
            end else if (r < 90) begin
                s = fill_layout(k, -1, 2);
                case ($urandom_range(0, 2))
                    0: s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
                    1: s = s.substr(0, s.len() - 2);
                    default: s = {s, "0"};
                endcase
                push_text(s, $urandom_range(0, 99) < 20);
            end else begin
                n = $urandom_range(0, 80);
                for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), i == n - 1);
                if (n == 0) push_end();
            end
            if (char_count >= next_drain) begin
                push_drain();
                next_drain = char_count + 500;
            end
        end

        @(posedge i_clk);
        while (!i_rst_n || text_q.size() != 0 || i_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[guid_text_parser] OK");
        end else begin
            $display("[guid_text_parser] ERROR");
        end
        $finish;
    end

endmodule
